// File: rtl/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types and constants of the RC channel frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CHAN_W  = 16;
	localparam int unsigned CFG_W   = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = 1;
	localparam int unsigned Q_CNT_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_FIRST  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_SECOND = 2'd3;

	localparam logic [BYTE_W-1:0] RST_HEADER_FIRST   = 8'd170;
	localparam logic [BYTE_W-1:0] RST_HEADER_SECOND  = 8'd187;
	localparam logic [BYTE_W-1:0] RST_TRAILER_FIRST  = 8'd204;
	localparam logic [BYTE_W-1:0] RST_TRAILER_SECOND = 8'd221;

	typedef enum logic [2:0] {
		CLS_HDR1      = 3'd0,
		CLS_HDR2      = 3'd1,
		CLS_TRL1      = 3'd2,
		CLS_TRL2      = 3'd3,
		CLS_DATA      = 3'd4,
		CLS_LINK_UP   = 3'd5,
		CLS_LINK_DOWN = 3'd6
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [BYTE_W-1:0] data;
	} item_t;

endpackage

// File: rtl/rcfp_front.sv
// ----------------------------------------------------------------------------
// rcfp_front
// Holds the marker registers, accepts items and classifies each byte.
// ----------------------------------------------------------------------------
module rcfp_front
	import rcfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 link_level,
	input  logic                 q_full,
	output logic                 q_push,
	output item_t                q_item
);

	logic [BYTE_W-1:0] hdr1_q, hdr2_q, trl1_q, trl2_q;
	cls_t cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q <= RST_HEADER_FIRST;
			hdr2_q <= RST_HEADER_SECOND;
			trl1_q <= RST_TRAILER_FIRST;
			trl2_q <= RST_TRAILER_SECOND;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_FIRST:   hdr1_q <= cfg_data;
				CFG_HEADER_SECOND:  hdr2_q <= cfg_data;
				CFG_TRAILER_FIRST:  trl1_q <= cfg_data;
				CFG_TRAILER_SECOND: trl2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// first matching marker wins
	always_comb begin
		if (req_type)
			cls = link_level ? CLS_LINK_UP : CLS_LINK_DOWN;
		else if (rx_byte == hdr1_q)
			cls = CLS_HDR1;
		else if (rx_byte == hdr2_q)
			cls = CLS_HDR2;
		else if (rx_byte == trl1_q)
			cls = CLS_TRL1;
		else if (rx_byte == trl2_q)
			cls = CLS_TRL2;
		else
			cls = CLS_DATA;
	end

	assign in_stall    = q_full;
	assign q_push      = in_valid && !q_full;
	assign q_item.cls  = cls;
	assign q_item.data = rx_byte;

endmodule

// File: rtl/rcfp_queue.sv
// ----------------------------------------------------------------------------
// rcfp_queue
// Two-entry item queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module rcfp_queue
	import rcfp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t pop_item
);

	item_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;

	assign full     = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: rtl/rcfp_back.sv
// ----------------------------------------------------------------------------
// rcfp_back
// Frame state machine, channel store and result register.
// ----------------------------------------------------------------------------
module rcfp_back
	import rcfp_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = 4
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              connected,
	output logic              receiving,
	output logic              frame_done,
	output logic [CHAN_W-1:0] channel_0,
	output logic [CHAN_W-1:0] channel_1,
	output logic [CHAN_W-1:0] channel_2,
	output logic [CHAN_W-1:0] channel_3
);

	localparam int unsigned IDX_W = $clog2(NUM_CHANNELS + 1);
	localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(NUM_CHANNELS);

	typedef enum logic [4:0] {
		PH_DISC    = 5'b00001,
		PH_WAITING = 5'b00010,
		PH_START   = 5'b00100,
		PH_READING = 5'b01000,
		PH_STOP    = 5'b10000
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               hi_q, hi_d;
	logic               done_q, done_d;
	logic               valid_q;
	logic               take, store;
	logic [CHAN_W-1:0]  ch_q [NUM_CHANNELS];
	logic [CHAN_W-1:0]  ch_out [4];

	assign q_pop = !q_empty && (!valid_q || !out_stall);
	assign store = take && (idx_q != IDX_FULL);

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		hi_d    = hi_q;
		done_d  = 1'b0;
		take    = 1'b0;
		case (q_item.cls)
			CLS_LINK_UP:   phase_d = PH_WAITING;
			CLS_LINK_DOWN: phase_d = PH_DISC;
			CLS_HDR1: begin
				if (phase_q == PH_WAITING)
					phase_d = PH_START;
				else if (phase_q == PH_READING)
					take = 1'b1;
			end
			CLS_HDR2: begin
				if (phase_q == PH_START) begin
					phase_d = PH_READING;
					idx_d   = '0;
				end else if (phase_q == PH_READING) begin
					take = 1'b1;
				end
			end
			CLS_TRL1: begin
				if (phase_q == PH_READING) begin
					if (idx_q == IDX_FULL)
						phase_d = PH_STOP;
					else
						take = 1'b1;
				end
			end
			CLS_TRL2: begin
				if (phase_q == PH_STOP) begin
					phase_d = PH_WAITING;
					done_d  = 1'b1;
				end else if (phase_q == PH_READING) begin
					take = 1'b1;
				end
			end
			CLS_DATA: begin
				if (phase_q == PH_READING)
					take = 1'b1;
			end
			default: ;
		endcase
		if (store) begin
			hi_d = !hi_q;
			if (!hi_q)
				idx_d = idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DISC;
			idx_q   <= '0;
			hi_q    <= 1'b1;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
				hi_q    <= hi_d;
				done_q  <= done_d;
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_chan
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ch_q[k] <= '0;
			else if (q_pop && store && idx_q == IDX_W'(k)) begin
				if (hi_q)
					ch_q[k] <= {q_item.data, {BYTE_W{1'b0}}};
				else
					ch_q[k] <= ch_q[k] | {{(CHAN_W-BYTE_W){1'b0}}, q_item.data};
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_out
		if (k < NUM_CHANNELS) begin : g_used
			assign ch_out[k] = ch_q[k];
		end else begin : g_unused
			assign ch_out[k] = '0;
		end
	end

	assign out_valid  = valid_q;
	assign connected  = (phase_q != PH_DISC);
	assign receiving  = (phase_q == PH_READING);
	assign frame_done = done_q;
	assign channel_0  = ch_out[0];
	assign channel_1  = ch_out[1];
	assign channel_2  = ch_out[2];
	assign channel_3  = ch_out[3];

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_FULL)
		else $error("channel index beyond channel count");

	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> phase_q == PH_WAITING)
		else $error("frame done without return to waiting");

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !q_pop)
		else $error("item popped while result stalled");

	a_done_needs_stop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && done_d |-> phase_q == PH_STOP)
		else $error("frame closed outside stop phase");

endmodule

// File: rtl/rc_channel_frame_parser_core.sv
// ----------------------------------------------------------------------------
// rc_channel_frame_parser_core
// Path: an accepted item goes into the queue, then into the result register.
// Throughput: one item per cycle while out_stall is low; the two-entry queue
// and the result register decouple input stall from output stall.
// Reset: asynchronous, active low; link disconnected, channels zero, marker
// registers at their defaults.
// ----------------------------------------------------------------------------
module rc_channel_frame_parser_core
	import rcfp_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = 4
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 link_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 connected,
	output logic                 receiving,
	output logic                 frame_done,
	output logic [CHAN_W-1:0]    channel_0,
	output logic [CHAN_W-1:0]    channel_1,
	output logic [CHAN_W-1:0]    channel_2,
	output logic [CHAN_W-1:0]    channel_3
);

	logic  q_full, q_push, q_empty, q_pop;
	item_t push_item, pop_item;

	rcfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.rx_byte    (rx_byte),
		.link_level (link_level),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	rcfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	rcfp_back #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_item     (pop_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.connected  (connected),
		.receiving  (receiving),
		.frame_done (frame_done),
		.channel_0  (channel_0),
		.channel_1  (channel_1),
		.channel_2  (channel_2),
		.channel_3  (channel_3)
	);

endmodule
